// ===== src/ocpm_pkg.sv =====
// Overcurrent protection monitor: shared types, constants and register map.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ocpm_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Block sum holds up to 128 full-scale samples
  localparam int unsigned SUM_W      = 17;
  // Scaled sum plus rounding term: sum * 64 + samples / 2
  localparam int unsigned FRAC_W     = 6;
  localparam int unsigned NUM_W      = SUM_W + FRAC_W;

  localparam int unsigned AVG_SAMPLES_DEF = 100;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] LIMIT_HIGH_RST   = SAMPLE_W'(880);
  localparam logic [SAMPLE_W-1:0] LIMIT_LOW_RST    = SAMPLE_W'(400);
  localparam logic [MS_W-1:0]     WINDOW_MS_RST    = MS_W'(2000);
  localparam logic [COUNT_W-1:0]  TRIP_COUNT_RST   = COUNT_W'(3);
  localparam logic [COUNT_W-1:0]  SHUTDOWN_LIM_RST = COUNT_W'(3);
  localparam logic [MS_W-1:0]     COOLDOWN_MS_RST  = MS_W'(2500);
  localparam logic [MS_W-1:0]     CLEAR_MS_RST     = MS_W'(65000);

  localparam logic [COUNT_W-1:0]  COUNT_MAX        = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_HIGH   = 3'd0,
    REG_LIMIT_LOW    = 3'd1,
    REG_WINDOW_MS    = 3'd2,
    REG_TRIP_COUNT   = 3'd3,
    REG_SHUTDOWN_LIM = 3'd4,
    REG_COOLDOWN_MS  = 3'd5,
    REG_CLEAR_MS     = 3'd6,
    REG_ENABLE       = 3'd7
  } ocpm_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] limit_high;
    logic [SAMPLE_W-1:0] limit_low;
    logic [MS_W-1:0]     trigger_window_ms;
    logic [COUNT_W-1:0]  triggers_to_trip;
    logic [COUNT_W-1:0]  shutdown_limit;
    logic [MS_W-1:0]     cooldown_ms;
    logic [MS_W-1:0]     count_clear_ms;
    logic                monitor_enable;
  } ocpm_cfg_t;

  // One classified word between front and back
  typedef struct packed {
    logic              oob;
    logic [TIME_W-1:0] now_ms;
    logic              avg_last;
    logic [SUM_W-1:0]  avg_sum;
  } ocpm_entry_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ===== src/overcurrent_protection_monitor.sv =====
// Overcurrent protection monitor top level: register file, front end, queue
// and back end. Depends on ocpm_pkg, ocpm_front, ocpm_queue and ocpm_back.
//
//   channel  signals                        direction  word
//   in       in_valid_i / in_ready_o        input      sample_i, now_ms_i
//   out      out_valid_o / out_ready_i      output     nine result fields
//   cfg      cfg_we_i                       input      cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while out_ready_i stays high; the word lands in
// the two-entry queue, and the back end loads the output register when it
// pops the word. The back end's combinational state update and
// divide-by-reciprocal multiply set the rate. Reset restores the configuration
// and protection state to their defaults; result fields and queue storage are
// not reset. A stalled output holds the result register; the queue absorbs up to two words before in_ready_o drops.
`timescale 1ns / 1ps

module overcurrent_protection_monitor import ocpm_pkg::*; #(
  parameter int unsigned AVG_SAMPLES = AVG_SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  shut_down_o,
  output logic                  waiting_o,
  output logic                  waiting_first_o,
  output logic                  reactivate_o,
  output logic                  over_limit_o,
  output logic                  over_limit_first_o,
  output logic                  avg_valid_o,
  output logic [AVG_W-1:0]      average_o,
  output logic [COUNT_W-1:0]    trigger_count_o
);

  ocpm_cfg_t   cfg_q, cfg_d;
  ocpm_entry_t push_entry, pop_entry;
  logic        push, pop, q_full, q_valid;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ocpm_reg_e'(cfg_idx_i))
        REG_LIMIT_HIGH:   cfg_d.limit_high        = cfg_data_i[SAMPLE_W-1:0];
        REG_LIMIT_LOW:    cfg_d.limit_low         = cfg_data_i[SAMPLE_W-1:0];
        REG_WINDOW_MS:    cfg_d.trigger_window_ms = cfg_data_i[MS_W-1:0];
        REG_TRIP_COUNT:   cfg_d.triggers_to_trip  = cfg_data_i[COUNT_W-1:0];
        REG_SHUTDOWN_LIM: cfg_d.shutdown_limit    = cfg_data_i[COUNT_W-1:0];
        REG_COOLDOWN_MS:  cfg_d.cooldown_ms       = cfg_data_i[MS_W-1:0];
        REG_CLEAR_MS:     cfg_d.count_clear_ms    = cfg_data_i[MS_W-1:0];
        REG_ENABLE:       cfg_d.monitor_enable    = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_high        <= LIMIT_HIGH_RST;
      cfg_q.limit_low         <= LIMIT_LOW_RST;
      cfg_q.trigger_window_ms <= WINDOW_MS_RST;
      cfg_q.triggers_to_trip  <= TRIP_COUNT_RST;
      cfg_q.shutdown_limit    <= SHUTDOWN_LIM_RST;
      cfg_q.cooldown_ms       <= COOLDOWN_MS_RST;
      cfg_q.count_clear_ms    <= CLEAR_MS_RST;
      cfg_q.monitor_enable    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ocpm_front #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .now_ms_i   (now_ms_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  ocpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  ocpm_back #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_valid_i          (q_valid),
    .entry_i            (pop_entry),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .shut_down_o        (shut_down_o),
    .waiting_o          (waiting_o),
    .waiting_first_o    (waiting_first_o),
    .reactivate_o       (reactivate_o),
    .over_limit_o       (over_limit_o),
    .over_limit_first_o (over_limit_first_o),
    .avg_valid_o        (avg_valid_o),
    .average_o          (average_o),
    .trigger_count_o    (trigger_count_o)
  );

endmodule

// ===== src/ocpm_front.sv =====
// Front end: accepts sample words, flags out-of-band samples, builds block sums.
// Depends on ocpm_pkg; feeds ocpm_queue.
`timescale 1ns / 1ps

module ocpm_front import ocpm_pkg::*; #(
  parameter int unsigned AVG_SAMPLES = AVG_SAMPLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ocpm_cfg_t           cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [TIME_W-1:0]   now_ms_i,
  input  logic                q_full_i,
  output logic                push_o,
  output ocpm_entry_t         entry_o
);

  localparam int unsigned CNT_W = $clog2(AVG_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_SAMPLES - 1);

  logic [SUM_W-1:0] sum_q, sum_d, sum_new;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // Add the sample to the running block sum
  assign sum_new = sum_q + SUM_W'(sample_i);
  assign last    = (cnt_q == CNT_LAST);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (push_o) begin
      sum_d = last ? '0 : sum_new;
      cnt_d = last ? '0 : cnt_q + CNT_W'(1);
    end
  end

  // Classify the word
  always_comb begin
    entry_o.oob      = (sample_i >= cfg_i.limit_high) || (sample_i <= cfg_i.limit_low);
    entry_o.now_ms   = now_ms_i;
    entry_o.avg_last = last;
    entry_o.avg_sum  = sum_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/ocpm_queue.sv =====
// Short FIFO of classified words between front and back end.
// Depends on ocpm_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ocpm_queue import ocpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ocpm_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output ocpm_entry_t entry_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  ocpm_entry_t      mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== src/ocpm_back.sv =====
// Back end: trigger window, shutdown and cool-down state, block average
// and the registered result word. Depends on ocpm_pkg; fed by ocpm_queue.
`timescale 1ns / 1ps

module ocpm_back import ocpm_pkg::*; #(
  parameter int unsigned AVG_SAMPLES = AVG_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ocpm_cfg_t          cfg_i,
  input  logic               q_valid_i,
  input  ocpm_entry_t        entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               shut_down_o,
  output logic               waiting_o,
  output logic               waiting_first_o,
  output logic               reactivate_o,
  output logic               over_limit_o,
  output logic               over_limit_first_o,
  output logic               avg_valid_o,
  output logic [AVG_W-1:0]   average_o,
  output logic [COUNT_W-1:0] trigger_count_o
);

  // Exact divide by AVG_SAMPLES through a reciprocal
  localparam int unsigned SHIFT = NUM_W + $clog2(AVG_SAMPLES);
  localparam int unsigned MUL_W = NUM_W + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);
  localparam logic [NUM_W-1:0] ROUND = NUM_W'(AVG_SAMPLES / 2);

  // Protection state
  logic               insd_q, insd_d;
  logic               wo_q, wo_d;
  logic [COUNT_W-1:0] trig_q, trig_d;
  logic [TIME_W-1:0]  ws_q, ws_d;
  logic [TIME_W-1:0]  ss_q, ss_d;
  logic [COUNT_W-1:0] sc_q, sc_d;
  logic               fwm_q, fwm_d;
  logic               fom_q, fom_d;

  // Step flags
  logic               waiting, waiting_first, reactivate, over, over_first;

  // Average path
  logic [NUM_W-1:0]       num;
  logic [NUM_W+MUL_W-1:0] prod;
  logic [AVG_W-1:0]       avg;

  logic out_valid_q;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Scale, round and divide the block sum
  assign num  = {entry_i.avg_sum, {FRAC_W{1'b0}}} + ROUND;
  assign prod = (NUM_W + MUL_W)'(num) * (NUM_W + MUL_W)'(RECIP);
  assign avg  = entry_i.avg_last ? prod[SHIFT +: AVG_W] : '0;

  // Update the protection state for one word
  always_comb begin
    logic              opened;
    logic              trip;
    logic              at_limit;
    logic [TIME_W-1:0] diff_ws;
    logic [TIME_W-1:0] diff_ss;
    logic [TIME_W-1:0] win_age;
    logic [TIME_W-1:0] since_ss;

    insd_d = insd_q;
    wo_d   = wo_q;
    trig_d = trig_q;
    ws_d   = ws_q;
    ss_d   = ss_q;
    sc_d   = sc_q;
    fwm_d  = fwm_q;
    fom_d  = fom_q;

    waiting       = 1'b0;
    waiting_first = 1'b0;
    reactivate    = 1'b0;
    over          = 1'b0;
    over_first    = 1'b0;

    opened   = 1'b0;
    trip     = 1'b0;
    at_limit = 1'b0;
    diff_ws  = entry_i.now_ms - ws_q;
    diff_ss  = entry_i.now_ms - ss_q;
    win_age  = '0;
    since_ss = '0;

    if (cfg_i.monitor_enable) begin
      // Count triggers inside the window, trip or close it
      if (!insd_q) begin
        if (entry_i.oob) begin
          if (!wo_q) begin
            ws_d   = entry_i.now_ms;
            trig_d = '0;
            wo_d   = 1'b1;
            opened = 1'b1;
          end
          trig_d = sat_inc(trig_d);
        end
        win_age = opened ? '0 : diff_ws;
        if (wo_d) begin
          if (trig_d >= cfg_i.triggers_to_trip) begin
            ss_d   = entry_i.now_ms;
            insd_d = 1'b1;
            sc_d   = sat_inc(sc_q);
            trip   = 1'b1;
          end else if (win_age >= TIME_W'(cfg_i.trigger_window_ms)) begin
            wo_d   = 1'b0;
            trig_d = '0;
          end
        end
      end

      since_ss = trip ? '0 : diff_ss;

      // Hold through cool down, then reactivate
      if (insd_d) begin
        at_limit = (sc_d >= cfg_i.shutdown_limit);
        if (since_ss <= TIME_W'(cfg_i.cooldown_ms)) begin
          waiting       = 1'b1;
          waiting_first = fwm_q;
          fwm_d         = 1'b0;
        end else begin
          reactivate = 1'b1;
          insd_d     = 1'b0;
          wo_d       = 1'b0;
          trig_d     = '0;
          fwm_d      = 1'b1;
          if (at_limit) begin
            sc_d  = '0;
            fom_d = 1'b1;
          end
        end
        if (at_limit) begin
          over       = 1'b1;
          over_first = fom_d;
          fom_d      = 1'b0;
        end
      end

      // Drop the shutdown count after a long quiet time
      if ((since_ss > TIME_W'(cfg_i.count_clear_ms)) && (sc_d != '0)) begin
        sc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      insd_q      <= 1'b0;
      wo_q        <= 1'b0;
      trig_q      <= '0;
      ws_q        <= '0;
      ss_q        <= '0;
      sc_q        <= '0;
      fwm_q       <= 1'b1;
      fom_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        insd_q <= insd_d;
        wo_q   <= wo_d;
        trig_q <= trig_d;
        ws_q   <= ws_d;
        ss_q   <= ss_d;
        sc_q   <= sc_d;
        fwm_q  <= fwm_d;
        fom_q  <= fom_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      shut_down_o        <= insd_d;
      waiting_o          <= waiting;
      waiting_first_o    <= waiting_first;
      reactivate_o       <= reactivate;
      over_limit_o       <= over;
      over_limit_first_o <= over_first;
      avg_valid_o        <= entry_i.avg_last;
      average_o          <= avg;
      trigger_count_o    <= trig_d;
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench for overcurrent_protection_monitor: directed and random current samples,
// checked word by word against an in-bench model of trip, cool-down and averaging.
// Depends on ocpm_pkg and the RTL of the block; reads and writes no files.
`timescale 1ns / 1ps

module tb;
  import ocpm_pkg::*;

  localparam int unsigned AVG_N         = AVG_SAMPLES_DEF;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 6;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  localparam ocpm_cfg_t CFG_RST = '{
    limit_high:        LIMIT_HIGH_RST,
    limit_low:         LIMIT_LOW_RST,
    trigger_window_ms: WINDOW_MS_RST,
    triggers_to_trip:  TRIP_COUNT_RST,
    shutdown_limit:    SHUTDOWN_LIM_RST,
    cooldown_ms:       COOLDOWN_MS_RST,
    count_clear_ms:    CLEAR_MS_RST,
    monitor_enable:    1'b1
  };

  typedef struct packed {
    logic               shut_down;
    logic               waiting;
    logic               waiting_first;
    logic               reactivate;
    logic               over_limit;
    logic               over_limit_first;
    logic               avg_valid;
    logic [AVG_W-1:0]   average;
    logic [COUNT_W-1:0] trigger_count;
  } sense_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   sample;
  logic [TIME_W-1:0]     now_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic                  shut_down;
  logic                  waiting;
  logic                  waiting_first;
  logic                  reactivate;
  logic                  over_limit;
  logic                  over_limit_first;
  logic                  avg_valid;
  logic [AVG_W-1:0]      average;
  logic [COUNT_W-1:0]    trigger_count;
  sense_result_t         seen;

  // Expected results in acceptance order
  sense_result_t         outcome_q[$];
  int unsigned           err_cnt = 0;
  int unsigned           src_idle_pct = 28;
  int unsigned           snk_idle_pct = 82;
  logic                  hold_req = 1'b0;
  logic [TIME_W-1:0]     stamp;
  int unsigned           idle_cycles = 0;

  // Model state: configuration, protection and averaging
  ocpm_cfg_t             cfg_m;
  logic                  m_shut, m_win, m_wait_mark, m_over_mark;
  logic [COUNT_W-1:0]    m_trig, m_trips;
  logic [TIME_W-1:0]     m_win_t0, m_trip_t0;
  logic [SUM_W-1:0]      m_sum;
  int unsigned           m_len;

  overcurrent_protection_monitor #(.AVG_SAMPLES(AVG_N)) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .sample_i           (sample),
    .now_ms_i           (now_ms),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .shut_down_o        (shut_down),
    .waiting_o          (waiting),
    .waiting_first_o    (waiting_first),
    .reactivate_o       (reactivate),
    .over_limit_o       (over_limit),
    .over_limit_first_o (over_limit_first),
    .avg_valid_o        (avg_valid),
    .average_o          (average),
    .trigger_count_o    (trigger_count)
  );

  assign seen = {shut_down, waiting, waiting_first, reactivate, over_limit,
                 over_limit_first, avg_valid, average, trigger_count};

  always #2 clk = ~clk;

  // Restore model state to its power-up values
  function automatic void reset_model();
    cfg_m       = CFG_RST;
    m_shut      = 1'b0;
    m_win       = 1'b0;
    m_trig      = '0;
    m_win_t0    = '0;
    m_trip_t0   = '0;
    m_trips     = '0;
    m_wait_mark = 1'b1;
    m_over_mark = 1'b1;
    m_sum       = '0;
    m_len       = 0;
  endfunction

  // Advance the model by one sample and return the word it produces
  function automatic sense_result_t protect_and_average(input logic [SAMPLE_W-1:0] s,
                                                        input logic [TIME_W-1:0] t);
    sense_result_t     r;
    logic              at_lim;
    logic [TIME_W-1:0] dt;
    int unsigned       num;
    r = '0;

    // Accumulate the block and emit a rounded 10.6 average on its last sample
    m_sum = m_sum + SUM_W'(s);
    m_len++;
    if (m_len >= AVG_N) begin
      num = m_sum;
      num = (num * 64 + AVG_N / 2) / AVG_N;
      r.average   = num[AVG_W-1:0];
      r.avg_valid = 1'b1;
      m_sum = '0;
      m_len = 0;
    end

    if (cfg_m.monitor_enable) begin
      // Count triggers in the window and trip or close it
      if (!m_shut) begin
        if (s >= cfg_m.limit_high || s <= cfg_m.limit_low) begin
          if (!m_win) begin
            m_win_t0 = t;
            m_trig   = '0;
            m_win    = 1'b1;
          end
          if (m_trig != COUNT_MAX) m_trig++;
        end
        if (m_win) begin
          dt = t - m_win_t0;
          if (m_trig >= cfg_m.triggers_to_trip) begin
            m_trip_t0 = t;
            m_shut    = 1'b1;
            if (m_trips != COUNT_MAX) m_trips++;
          end else if (dt >= TIME_W'(cfg_m.trigger_window_ms)) begin
            m_win  = 1'b0;
            m_trig = '0;
          end
        end
      end

      // Hold off until cool-down ends, flag repeated shutdowns
      if (m_shut) begin
        at_lim = (m_trips >= cfg_m.shutdown_limit);
        dt = t - m_trip_t0;
        if (dt <= TIME_W'(cfg_m.cooldown_ms)) begin
          r.waiting       = 1'b1;
          r.waiting_first = m_wait_mark;
          m_wait_mark     = 1'b0;
        end else begin
          r.reactivate = 1'b1;
          m_shut       = 1'b0;
          m_win        = 1'b0;
          m_trig       = '0;
          m_wait_mark  = 1'b1;
          if (at_lim) begin
            m_trips     = '0;
            m_over_mark = 1'b1;
          end
        end
        if (at_lim) begin
          r.over_limit       = 1'b1;
          r.over_limit_first = m_over_mark;
          m_over_mark        = 1'b0;
        end
      end

      // Forget old shutdowns after the clear time
      dt = t - m_trip_t0;
      if (dt > TIME_W'(cfg_m.count_clear_ms) && m_trips != '0) m_trips = '0;
    end

    r.shut_down     = m_shut;
    r.trigger_count = m_trig;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : result_check
    sense_result_t want;
    if (out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, seen);
        err_cnt++;
      end else begin
        want = outcome_q.pop_front();
        check_field("shut_down", want.shut_down, seen.shut_down);
        check_field("waiting", want.waiting, seen.waiting);
        check_field("waiting_first", want.waiting_first, seen.waiting_first);
        check_field("reactivate", want.reactivate, seen.reactivate);
        check_field("over_limit", want.over_limit, seen.over_limit);
        check_field("over_limit_first", want.over_limit_first, seen.over_limit_first);
        check_field("avg_valid", want.avg_valid, seen.avg_valid);
        check_field("average", want.average, seen.average);
        check_field("trigger_count", want.trigger_count, seen.trigger_count);
      end
    end
  end

  // Drop out_ready at random, or for a long stretch on request
  initial begin : ready_gen
    int unsigned hold_left;
    out_ready = 1'b0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one sample and record its expected word on acceptance
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    now_ms   <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_q.push_back(protect_and_average(s, t));
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected word is back
  task automatic settle();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all registers, optionally with junk above each register's width
  task automatic load_config(input ocpm_cfg_t c, input logic junk);
    ocpm_reg_e             r;
    logic [CFG_DATA_W-1:0] v;
    int                    i;
    for (i = 0; i < r.num(); i++) begin
      r = ocpm_reg_e'(i);
      v = junk ? CFG_DATA_W'($urandom) : '0;
      case (r)
        REG_LIMIT_HIGH:   v[SAMPLE_W-1:0] = c.limit_high;
        REG_LIMIT_LOW:    v[SAMPLE_W-1:0] = c.limit_low;
        REG_WINDOW_MS:    v = c.trigger_window_ms;
        REG_TRIP_COUNT:   v[COUNT_W-1:0] = c.triggers_to_trip;
        REG_SHUTDOWN_LIM: v[COUNT_W-1:0] = c.shutdown_limit;
        REG_COOLDOWN_MS:  v = c.cooldown_ms;
        REG_CLEAR_MS:     v = c.count_clear_ms;
        REG_ENABLE:       v[0] = c.monitor_enable;
        default: ;
      endcase
      cfg_we   <= 1'b1;
      cfg_idx  <= r;
      cfg_data <= v;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cfg_m = c;
  endtask

  function automatic ocpm_cfg_t random_config();
    ocpm_cfg_t c;
    logic      hi;
    c.limit_high        = SAMPLE_W'($urandom_range(1023, 560));
    c.limit_low         = SAMPLE_W'($urandom_range(460, 0));
    c.trigger_window_ms = MS_W'($urandom_range(3000, 0));
    c.triggers_to_trip  = COUNT_W'($urandom_range(6, 0));
    c.shutdown_limit    = COUNT_W'($urandom_range(5, 0));
    c.cooldown_ms       = MS_W'($urandom_range(3000, 0));
    c.count_clear_ms    = MS_W'($urandom_range(20000, 0));
    c.monitor_enable    = ($urandom_range(9) != 0);
    // Pin one register to an end of its range now and then
    hi = $urandom_range(1);
    case ($urandom_range(9))
      0: c.limit_high        = {SAMPLE_W{hi}};
      1: c.limit_low         = {SAMPLE_W{hi}};
      2: c.trigger_window_ms = {MS_W{hi}};
      3: c.triggers_to_trip  = {COUNT_W{hi}};
      4: c.shutdown_limit    = {COUNT_W{hi}};
      5: c.cooldown_ms       = {MS_W{hi}};
      6: c.count_clear_ms    = {MS_W{hi}};
      default: ;
    endcase
    return c;
  endfunction

  // Quiet, faulty, fully random or rail samples depending on burst kind
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned kind);
    logic fault;
    case (kind)
      8: return SAMPLE_W'($urandom_range(1023));
      9: return $urandom_range(1) ? SAMPLE_MAX : '0;
      default: fault = (kind >= 4) ? ($urandom_range(4) != 0) : ($urandom_range(19) == 0);
    endcase
    if (fault) begin
      if ($urandom_range(1)) return SAMPLE_W'($urandom_range(1023, cfg_m.limit_high));
      return SAMPLE_W'($urandom_range(cfg_m.limit_low, 0));
    end
    if (cfg_m.limit_high > cfg_m.limit_low + 1)
      return SAMPLE_W'($urandom_range(cfg_m.limit_high - 1, cfg_m.limit_low + 1));
    return SAMPLE_W'($urandom_range(1023));
  endfunction

  // Mostly short steps, some long ones, rare backward and wild jumps
  function automatic void advance_stamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60)      stamp += $urandom_range(40);
    else if (r < 85) stamp += $urandom_range(1500);
    else if (r < 96) stamp += $urandom_range(4000);
    else if (r < 99) stamp -= $urandom_range(100);
    else             stamp = $urandom;
  endfunction

  task automatic run_traffic(input int unsigned n);
    int unsigned left, kind, burst, j;
    left = n;
    while (left != 0) begin
      kind  = $urandom_range(9);
      burst = $urandom_range(12, 1);
      for (j = 0; j < burst && left != 0; j++) begin
        advance_stamp();
        push_sample(pick_sample(kind), stamp);
        left--;
      end
    end
  endtask

  // Reset values: trip on three triggers, wait out the cool-down, reactivate
  task automatic test_default_trip();
    settle();
    push_sample(10'd500, 32'd1000);
    push_sample(10'd900, 32'd1010);
    push_sample(10'd400, 32'd1020);
    push_sample(SAMPLE_MAX, 32'd1030);
    push_sample(10'd600, 32'd3530);
    push_sample(10'd600, 32'd3531);
    push_sample(10'd0, 32'd3532);
  endtask

  // Limits at the rails, timestamps across the wrap and out of order
  task automatic test_extreme_stamps();
    ocpm_cfg_t c;
    settle();
    c = CFG_RST;
    c.limit_high        = SAMPLE_MAX;
    c.limit_low         = '0;
    c.trigger_window_ms = MS_W'(5);
    c.triggers_to_trip  = COUNT_W'(2);
    c.shutdown_limit    = COUNT_W'(1);
    c.cooldown_ms       = '0;
    c.count_clear_ms    = '1;
    load_config(c, 1'b1);
    push_sample(10'd512, 32'hFFFF_FFFE);
    push_sample(SAMPLE_MAX, 32'hFFFF_FFFF);
    push_sample(10'd0, 32'h0000_0003);
    push_sample(10'd0, 32'h0000_0004);
    push_sample(SAMPLE_MAX, 32'h0000_0000);
    push_sample(10'd512, 32'h0000_0005);
  endtask

  // Zero trip threshold, over-limit marks, count clear, zero shutdown limit
  task automatic test_over_limit_marks();
    ocpm_cfg_t c;
    settle();
    c = CFG_RST;
    c.triggers_to_trip = '0;
    c.shutdown_limit   = COUNT_W'(2);
    c.cooldown_ms      = MS_W'(10);
    c.count_clear_ms   = '1;
    load_config(c, 1'b0);
    push_sample(SAMPLE_MAX, 32'd100);
    push_sample(10'd500, 32'd111);
    push_sample(10'd0, 32'd120);
    push_sample(10'd500, 32'd125);
    push_sample(10'd500, 32'd131);
    push_sample(SAMPLE_MAX, 32'd140);
    settle();
    c.count_clear_ms = MS_W'(5);
    c.shutdown_limit = '0;
    load_config(c, 1'b0);
    push_sample(10'd500, 32'd200);
    push_sample(SAMPLE_MAX, 32'd210);
  endtask

  // Disabled monitor freezes triggers and the shutdown state
  task automatic test_disabled_freeze();
    ocpm_cfg_t c;
    settle();
    c = CFG_RST;
    c.triggers_to_trip = COUNT_W'(5);
    c.cooldown_ms      = MS_W'(50);
    load_config(c, 1'b0);
    push_sample(10'd1000, 32'd20000);
    push_sample(10'd0, 32'd20010);
    settle();
    c.monitor_enable = 1'b0;
    load_config(c, 1'b0);
    push_sample(SAMPLE_MAX, 32'd20020);
    settle();
    c.monitor_enable   = 1'b1;
    c.triggers_to_trip = COUNT_W'(1);
    load_config(c, 1'b0);
    push_sample(SAMPLE_MAX, 32'd40010);
    settle();
    c.monitor_enable = 1'b0;
    load_config(c, 1'b0);
    push_sample(10'd500, 32'd50000);
    settle();
    c.monitor_enable = 1'b1;
    load_config(c, 1'b0);
    push_sample(10'd500, 32'd50001);
  endtask

  // Run the trigger count up to its maximum before tripping
  task automatic test_trip_at_max();
    ocpm_cfg_t c;
    settle();
    c = CFG_RST;
    c.limit_high        = SAMPLE_MAX;
    c.limit_low         = '0;
    c.trigger_window_ms = '1;
    c.triggers_to_trip  = COUNT_MAX;
    c.shutdown_limit    = COUNT_MAX;
    c.cooldown_ms       = '0;
    load_config(c, 1'b0);
    stamp = 32'd7000;
    repeat (COUNT_MAX + 3) begin
      stamp += 1;
      push_sample(SAMPLE_MAX, stamp);
    end
  endtask

  // Averaging only: full-scale and zero blocks
  task automatic test_average_rails();
    ocpm_cfg_t c;
    settle();
    c = CFG_RST;
    c.monitor_enable = 1'b0;
    load_config(c, 1'b0);
    while (m_len != 0) begin
      stamp += 7;
      push_sample(SAMPLE_W'($urandom_range(1023)), stamp);
    end
    repeat (AVG_N) begin
      stamp += 7;
      push_sample(SAMPLE_MAX, stamp);
    end
    repeat (AVG_N) begin
      stamp += 7;
      push_sample('0, stamp);
    end
  endtask

  task automatic test_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                   input int unsigned chunks);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (chunks) begin
      settle();
      load_config(random_config(), 1'(($urandom_range(1))));
      case ($urandom_range(3))
        0: stamp = $urandom;
        1: stamp = 32'hFFFF_FFFF - $urandom_range(5000);
        default: ;
      endcase
      run_traffic($urandom_range(110, 70));
    end
  endtask

  // Hold the receiver off while the sender keeps offering words
  task automatic test_backpressure();
    settle();
    load_config(CFG_RST, 1'b0);
    src_idle_pct = 0;
    hold_req     = 1'b1;
    run_traffic(60);
  endtask

  initial begin : main_seq
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_LIMIT_HIGH;
    cfg_data = '0;
    in_valid = 1'b0;
    sample   = '0;
    now_ms   = '0;
    stamp    = '0;
    reset_model();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_default_trip();
    test_extreme_stamps();
    test_over_limit_marks();
    test_disabled_freeze();
    test_trip_at_max();
    test_average_rails();
    test_random_phase(28, 82, 4);
    test_random_phase(82, 28, 4);
    test_random_phase(0, 0, 4);
    test_backpressure();
    settle();

    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== overcurrent_protection_monitor.f =====
src/ocpm_pkg.sv
src/ocpm_front.sv
src/ocpm_queue.sv
src/ocpm_back.sv
src/overcurrent_protection_monitor.sv
sim/tb.sv
